/* rtl/spectrum_bar_wand_display_unit_macros.svh */
// Assertion macros shared by the display unit.
`ifndef SPECTRUM_BAR_WAND_DISPLAY_UNIT_MACROS_SVH
`define SPECTRUM_BAR_WAND_DISPLAY_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define SBWD_ASSERT_HOLD(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");
`define SBWD_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");
`else
`define SBWD_ASSERT_HOLD(label, clk, rst_n, cond, expr)
`define SBWD_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif

`endif

/* rtl/sbwd_pkg.sv */
package sbwd_pkg;

    localparam int COLUMN_COUNT = 16;
    localparam int COL_W = $clog2(COLUMN_COUNT);

    localparam logic [15:0] DECAY_RATE_RESET = 16'd14285;
    localparam logic [19:0] US_MAX = 20'd1000000;
    localparam logic [35:0] ROUND_UP = 36'd999999;

    // The divide by one million is a shift right by six and a multiply by the rounded-up
    // reciprocal of 15625; the quotient is exact for every numerator below 2^36.
    localparam logic [30:0] DEC_RECIP = 31'd1125899907;
    localparam int DEC_SHIFT = 44;

    localparam logic [7:0] BAND_EDGE [COLUMN_COUNT] = '{
        8'd0, 8'd1, 8'd2, 8'd3, 8'd5, 8'd7, 8'd10, 8'd14,
        8'd20, 8'd28, 8'd40, 8'd54, 8'd74, 8'd101, 8'd137, 8'd187
    };

    localparam logic [6:0] LEVEL_EDGE [8] = '{
        7'd2, 7'd3, 7'd4, 7'd5, 7'd8, 7'd11, 7'd16, 7'd24
    };

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SAMPLE = 6'b000010,
        ST_MUL    = 6'b000100,
        ST_DIV    = 6'b001000,
        ST_LEVEL  = 6'b010000,
        ST_EMIT   = 6'b100000
    } state_t;

    // Returns COLUMN_COUNT for a bin that is not displayed.
    function automatic logic [COL_W:0] bin_to_column(input logic [7:0] bin);
        logic [COL_W:0] col;
        col = (COL_W + 1)'(COLUMN_COUNT);
        for (int c = COLUMN_COUNT - 1; c >= 0; c--) begin
            if (bin <= BAND_EDGE[c]) begin
                col = (COL_W + 1)'(c);
            end
        end
        return col;
    endfunction

    function automatic logic [3:0] peak_to_level(input logic [14:0] peak);
        logic [3:0] lvl;
        lvl = 4'd0;
        for (int k = 0; k < 8; k++) begin
            if (peak[14:8] >= LEVEL_EDGE[k]) begin
                lvl = lvl + 4'd1;
            end
        end
        return lvl;
    endfunction

    function automatic logic [7:0] level_dot(input logic [3:0] lvl);
        logic [7:0] d;
        d = 8'h00;
        if (lvl != 4'd0 && lvl <= 4'd8) begin
            d = 8'h80 >> (lvl - 4'd1);
        end
        return d;
    endfunction

endpackage

/* rtl/spectrum_bar_wand_display_unit.sv */
// A sample is accepted, and its column peak is updated in the next cycle.
// A tick runs through its acceptance, one multiply, one reciprocal multiply
// for the divide by one million, the level and decay of the 16 columns in turn through the shared column unit,
// and 16 output items, one per cycle while m_tready stays high. No item is accepted meanwhile.
// Reset clears the control state and all column peaks at once and sets decay_rate to 14285.
`include "spectrum_bar_wand_display_unit_macros.svh"

module spectrum_bar_wand_display_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // bin_index[7:0], magnitude[23:8], elapsed_us[43:24]
    input  logic        s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // column_index[3:0], pattern[11:4]
    output logic        m_tlast
);

    localparam int CW = sbwd_pkg::COL_W;

    sbwd_pkg::state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [15:0]   decay_rate_reg;
    logic [7:0]    bin_reg;
    logic [15:0]   mag_reg;
    logic [19:0]   us_reg;
    logic [35:0]   num_reg, num_next;
    logic [15:0]   dec_reg, dec_next;
    logic [7:0]    sum_reg, sum_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [15:0]   m_tdata_reg;
    logic          m_tlast_reg;
    logic [14:0]   peak_reg [sbwd_pkg::COLUMN_COUNT];
    logic [3:0]    level_reg [sbwd_pkg::COLUMN_COUNT];

    logic          in_fire;
    logic          out_free;
    logic [19:0]   us_in;
    logic [35:0]   prod;
    logic [35:0]   num;
    logic [60:0]   recip_prod;
    logic [CW:0]   sample_col;
    logic [CW-1:0] peak_addr;
    logic [14:0]   peak_rd;
    logic [3:0]    lvl;
    logic [7:0]    lvl_add;
    logic          sample_wr;
    logic [14:0]   peak_decayed;
    logic [3:0]    mean;
    logic [7:0]    bar_mask;
    logic [7:0]    pattern;

    assign s_tready = (state_reg == sbwd_pkg::ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    assign us_in = (s_tdata[43:24] > sbwd_pkg::US_MAX) ? sbwd_pkg::US_MAX : s_tdata[43:24];

    assign prod = us_reg * decay_rate_reg;
    assign num  = prod + sbwd_pkg::ROUND_UP;

    assign recip_prod = num_reg[35:6] * sbwd_pkg::DEC_RECIP;

    assign sample_col = sbwd_pkg::bin_to_column(bin_reg);
    assign peak_addr  = (state_reg == sbwd_pkg::ST_SAMPLE) ? sample_col[CW-1:0] : cnt_reg;
    assign peak_rd    = peak_reg[peak_addr];
    assign sample_wr  = (state_reg == sbwd_pkg::ST_SAMPLE) && !sample_col[CW]
                        && !mag_reg[15] && (mag_reg[14:0] > peak_rd);

    assign lvl     = sbwd_pkg::peak_to_level(peak_rd);
    assign lvl_add = (cnt_reg < CW'(sbwd_pkg::COLUMN_COUNT / 4)) ? {3'b000, lvl, 1'b0}
                                                                  : {4'b0000, lvl};
    assign peak_decayed = ({1'b0, peak_rd} > dec_reg) ? (peak_rd - dec_reg[14:0]) : 15'd0;

    assign mean     = (sum_reg[7:4] > 4'd8) ? 4'd8 : sum_reg[7:4];
    assign bar_mask = ~(8'hFF >> mean);

    always_comb
    begin
        pattern = sbwd_pkg::level_dot(level_reg[cnt_reg]);
        if (mean != 4'd0)
        begin
            pattern = pattern ^ bar_mask;
        end
        else
        begin
            pattern = pattern ^ 8'h80;
            if (pattern == 8'h00)
            begin
                pattern = 8'h01;
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        num_next      = num_reg;
        dec_next      = dec_reg;
        sum_next      = sum_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            sbwd_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = s_tuser ? sbwd_pkg::ST_MUL : sbwd_pkg::ST_SAMPLE;
                end
            end
            sbwd_pkg::ST_SAMPLE:
            begin
                state_next = sbwd_pkg::ST_IDLE;
            end
            sbwd_pkg::ST_MUL:
            begin
                num_next   = num;
                sum_next   = 8'd0;
                cnt_next   = '0;
                state_next = sbwd_pkg::ST_DIV;
            end
            sbwd_pkg::ST_DIV:
            begin
                dec_next   = recip_prod[sbwd_pkg::DEC_SHIFT +: 16];
                state_next = sbwd_pkg::ST_LEVEL;
            end
            sbwd_pkg::ST_LEVEL:
            begin
                sum_next = sum_reg + lvl_add;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(sbwd_pkg::COLUMN_COUNT - 1))
                begin
                    state_next = sbwd_pkg::ST_EMIT;
                end
            end
            sbwd_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    cnt_next      = cnt_reg + 1'b1;
                    if (cnt_reg == CW'(sbwd_pkg::COLUMN_COUNT - 1))
                    begin
                        state_next = sbwd_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sbwd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sbwd_pkg::ST_IDLE;
            cnt_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
            decay_rate_reg <= sbwd_pkg::DECAY_RATE_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we)
            begin
                decay_rate_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        dec_reg <= dec_next;
        sum_reg <= sum_next;
        if (in_fire)
        begin
            bin_reg <= s_tdata[7:0];
            mag_reg <= s_tdata[23:8];
            us_reg  <= us_in;
        end
        if (state_reg == sbwd_pkg::ST_EMIT && out_free)
        begin
            m_tdata_reg <= {4'b0000, pattern, cnt_reg};
            m_tlast_reg <= (cnt_reg == CW'(sbwd_pkg::COLUMN_COUNT - 1));
        end
        if (state_reg == sbwd_pkg::ST_LEVEL)
        begin
            level_reg[cnt_reg] <= lvl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sbwd_pkg::COLUMN_COUNT; i++)
            begin
                peak_reg[i] <= 15'd0;
            end
        end
        else if (sample_wr)
        begin
            peak_reg[peak_addr] <= mag_reg[14:0];
        end
        else if (state_reg == sbwd_pkg::ST_LEVEL)
        begin
            peak_reg[peak_addr] <= peak_decayed;
        end
    end

    `SBWD_ASSERT_HOLD(a_last_on_final_column, clk, rst_n, m_tvalid && m_tlast, m_tdata[3:0] == 4'hF)
    `SBWD_ASSERT_NEXT(a_tick_starts_multiply, clk, rst_n, in_fire && s_tuser,
        state_reg == sbwd_pkg::ST_MUL)
    `SBWD_ASSERT_NEXT(a_levels_then_emit, clk, rst_n,
        state_reg == sbwd_pkg::ST_LEVEL && cnt_reg == CW'(sbwd_pkg::COLUMN_COUNT - 1),
        state_reg == sbwd_pkg::ST_EMIT && cnt_reg == '0)

endmodule

/* sim/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLUMN_COUNT = sbwd_pkg::COLUMN_COUNT;

    typedef enum bit
    {
        CMD_SAMPLE = 1'b0,
        CMD_TICK   = 1'b1
    } wand_cmd_t;

    typedef struct packed
    {
        wand_cmd_t   cmd;
        logic [7:0]  bin_index;
        logic [15:0] magnitude;
        logic [19:0] elapsed_us;
    } wand_item_t;

    typedef struct packed
    {
        logic [3:0] column_index;
        logic [7:0] pattern;
        logic       last;
    } column_byte_t;

    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [15:0] RATE_AT_RESET = 16'd14285;
    localparam logic [19:0] ONE_SECOND_US = 20'd1000000;

    localparam logic [7:0] BAND_TOP [COLUMN_COUNT] = '{
        8'd0, 8'd1, 8'd2, 8'd3, 8'd5, 8'd7, 8'd10, 8'd14,
        8'd20, 8'd28, 8'd40, 8'd54, 8'd74, 8'd101, 8'd137, 8'd187
    };

    localparam logic [6:0] LEVEL_FLOOR [8] = '{
        7'd2, 7'd3, 7'd4, 7'd5, 7'd8, 7'd11, 7'd16, 7'd24
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    logic [14:0]  peak_model [COLUMN_COUNT];
    logic [15:0]  rate_model;
    column_byte_t pending_bytes [$];

    int err_count = 0;
    int src_idle_pct = 7;
    int sink_idle_pct = 62;
    int hold_req = 0;
    int hold_served = 0;
    int hold_left = 0;
    int stall_cycles = 0;

    spectrum_bar_wand_display_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int column_of_bin(input logic [7:0] bin);
        for (int c = 0; c < COLUMN_COUNT; c++)
        begin
            if (bin <= BAND_TOP[c])
            begin
                return c;
            end
        end
        return COLUMN_COUNT;
    endfunction

    function automatic int level_of_peak(input logic [14:0] peak);
        int lvl;
        lvl = 0;
        if (peak > 15'd256)
        begin
            for (int k = 0; k < 8; k++)
            begin
                if (peak[14:8] >= LEVEL_FLOOR[k])
                begin
                    lvl++;
                end
            end
        end
        return lvl;
    endfunction

    // Updates the column peaks for one item and queues the frame that a tick produces.
    function automatic void predict_frame(input wand_item_t it);
        int               col;
        int               sum;
        int               mean;
        int               lvl [COLUMN_COUNT];
        longint unsigned  us;
        longint unsigned  drop;
        logic [7:0]       b;
        column_byte_t     cb;
        if (it.cmd == CMD_SAMPLE)
        begin
            col = column_of_bin(it.bin_index);
            if (col < COLUMN_COUNT && !it.magnitude[15] && it.magnitude[14:0] > peak_model[col])
            begin
                peak_model[col] = it.magnitude[14:0];
            end
            return;
        end
        us = (it.elapsed_us > ONE_SECOND_US) ? ONE_SECOND_US : it.elapsed_us;
        drop = (us * rate_model + 64'd999999) / 64'd1000000;
        sum = 0;
        for (int i = 0; i < COLUMN_COUNT; i++)
        begin
            lvl[i] = level_of_peak(peak_model[i]);
            sum += (i < COLUMN_COUNT / 4) ? 2 * lvl[i] : lvl[i];
            peak_model[i] = (peak_model[i] > drop) ? 15'(peak_model[i] - drop) : 15'd0;
        end
        mean = sum / 16;
        if (mean > 8)
        begin
            mean = 8;
        end
        for (int i = 0; i < COLUMN_COUNT; i++)
        begin
            b = (lvl[i] == 0) ? 8'h00 : (8'h80 >> (lvl[i] - 1));
            if (mean != 0)
            begin
                b ^= (8'hFF << (8 - mean));
            end
            else
            begin
                b ^= 8'h80;
                if (b == 8'h00)
                begin
                    b = 8'h01;
                end
            end
            cb.column_index = 4'(i);
            cb.pattern = b;
            cb.last = (i == COLUMN_COUNT - 1);
            pending_bytes.push_back(cb);
        end
    endfunction

    function automatic wand_item_t make_sample(input logic [7:0] bin, input logic [15:0] mag);
        wand_item_t it;
        it.cmd = CMD_SAMPLE;
        it.bin_index = bin;
        it.magnitude = mag;
        it.elapsed_us = 20'($urandom);
        return it;
    endfunction

    function automatic wand_item_t make_tick(input logic [19:0] us);
        wand_item_t it;
        it.cmd = CMD_TICK;
        it.bin_index = 8'($urandom);
        it.magnitude = 16'($urandom);
        it.elapsed_us = us;
        return it;
    endfunction

    function automatic wand_item_t random_item();
        wand_item_t it;
        it.cmd = ($urandom_range(7) == 0) ? CMD_TICK : CMD_SAMPLE;
        it.bin_index = ($urandom_range(4) == 0) ? 8'($urandom_range(255))
                                                : 8'($urandom_range(187));
        case ($urandom_range(3))
            0: it.magnitude = 16'($urandom);
            1: it.magnitude = 16'($urandom_range(1023));
            default: it.magnitude = 16'($urandom_range(8191));
        endcase
        it.elapsed_us = ($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(50000));
        return it;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("mismatch at %0t ns: %s expected %0d got %0d", $realtime, what, want, got);
        err_count++;
    endtask

    // Called at a falling edge; returns at the falling edge after the item is accepted.
    task automatic send_item(input wand_item_t it);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.cmd;
        s_tdata <= {4'd0, it.elapsed_us, it.magnitude, it.bin_index};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        predict_frame(it);
        @(negedge clk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_bytes.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_rate(input logic [15:0] rate);
        cfg_we <= 1'b1;
        cfg_wdata <= rate;
        @(negedge clk);
        cfg_we <= 1'b0;
        rate_model = rate;
    endtask

    task automatic test_level_dots_and_dropped_bins();
        send_item(make_tick(20'd0));
        send_item(make_sample(8'd255, 16'h7FFF));
        send_item(make_sample(8'd188, 16'h7FFF));
        send_item(make_sample(8'd1, 16'h8000));
        send_item(make_sample(8'd2, 16'd512));
        send_item(make_sample(8'd3, 16'd511));
        send_item(make_sample(8'd0, 16'd257));
        send_item(make_tick(20'd0));
        send_item(make_sample(8'd187, 16'd6144));
        send_item(make_sample(8'd137, 16'd6143));
        send_item(make_tick(20'hFFFFF));
        send_item(make_tick(20'd1));
        drain_results();
    endtask

    task automatic test_mean_clamp();
        for (int c = 0; c < 14; c++)
        begin
            send_item(make_sample(BAND_TOP[c], 16'h7FFF));
        end
        send_item(make_tick(20'hFFFFF));
        drain_results();
    endtask

    task automatic test_decay_rate_extremes();
        write_rate(16'hFFFF);
        send_item(make_tick(ONE_SECOND_US));
        send_item(make_tick(20'd0));
        drain_results();
        write_rate(16'h0000);
        send_item(make_sample(8'd0, 16'h7FFF));
        send_item(make_tick(20'hFFFFF));
        send_item(make_tick(20'd0));
        drain_results();
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct,
                                       input logic [15:0] rate, input int count);
        wand_item_t it;
        int         sent;
        sent = 0;
        @(posedge clk);
        src_idle_pct = tx_pct;
        sink_idle_pct = rx_pct;
        @(negedge clk);
        write_rate(rate);
        while (sent < count)
        begin
            it = random_item();
            send_item(it);
            if (it.cmd == CMD_TICK || column_of_bin(it.bin_index) < COLUMN_COUNT)
            begin
                sent++;
            end
        end
        drain_results();
    endtask

    // The receiver stops for a long stretch while ticks and samples keep coming, so the
    // unit has to hold its input back.
    task automatic test_output_hold();
        write_rate(RATE_AT_RESET);
        send_item(make_sample(8'd4, 16'd3000));
        @(posedge clk);
        hold_req++;
        @(negedge clk);
        send_item(make_tick(20'd20000));
        for (int i = 0; i < 10; i++)
        begin
            send_item(make_sample(8'($urandom_range(187)), 16'($urandom_range(8191))));
        end
        send_item(make_tick(20'd5000));
        drain_results();
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_req)
        begin
            m_tready <= 1'b0;
            hold_served <= hold_req;
            hold_left <= HOLD_CYCLES;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        column_byte_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_bytes.size() == 0)
            begin
                report_mismatch("column byte with none pending, column", -1, m_tdata[3:0]);
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (m_tdata[3:0] !== want.column_index)
                begin
                    report_mismatch("column_index", want.column_index, m_tdata[3:0]);
                end
                if (m_tdata[11:4] !== want.pattern)
                begin
                    report_mismatch("pattern", want.pattern, m_tdata[11:4]);
                end
                if (m_tlast !== want.last)
                begin
                    report_mismatch("last", want.last, m_tlast);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles < STALL_LIMIT)
        begin
            stall_cycles <= stall_cycles + 1;
        end
        else
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        rate_model = RATE_AT_RESET;
        for (int i = 0; i < COLUMN_COUNT; i++)
        begin
            peak_model[i] = '0;
        end
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_level_dots_and_dropped_bins();
        test_mean_clamp();
        test_decay_rate_extremes();
        test_random_traffic(7, 62, 16'($urandom_range(1, 65534)), 40);
        test_random_traffic(62, 7, 16'hFFFF, 40);
        test_random_traffic(0, 0, 16'($urandom_range(1, 65534)), 35);
        test_output_hold();

        repeat (60) @(negedge clk);
        if (pending_bytes.size() != 0)
        begin
            report_mismatch("column bytes still pending", 0, pending_bytes.size());
        end
        if (err_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/sbwd_pkg.sv
rtl/spectrum_bar_wand_display_unit.sv
sim/tb.sv
